@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/stre_pkg.sv @@
// ---------------------------------------------------------------------------
// stre_pkg
// Types and constants shared by the root election front end, queues and
// execution unit.
// ---------------------------------------------------------------------------
package stre_pkg;

	localparam int FUNC_W  = 2;
	localparam int IDX_W   = 4;
	localparam int VAL_W   = 8;
	localparam int ID_W    = 8;
	localparam int COST_W  = 12;
	localparam int CNT_W   = 5;
	localparam int NCNT_W  = 5;

	localparam int ID_MAX   = 255;
	localparam int COST_MAX = 255;

	localparam logic [COST_W-1:0] COST_SAT   = 12'd4095;
	localparam logic [CNT_W-1:0]  COUNT_SAT  = 5'd31;
	localparam logic [NCNT_W-1:0] NCNT_RESET = 5'd16;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_ID   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_LINK = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_UPDATE    = 2'd2;

	typedef enum logic [2:0] {
		OP_LOAD_ID,
		OP_LOAD_LINK,
		OP_UPDATE,
		OP_SHOW,
		OP_BLANK
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ_ME,
		ST_LINK2,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} st_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] node;
		logic [IDX_W-1:0] peer;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0]   bridge;
		logic [ID_W-1:0]   root;
		logic [ID_W-1:0]   hop;
		logic [COST_W-1:0] cost;
	} node_t;

	typedef struct packed {
		logic [ID_W-1:0]   root;
		logic [ID_W-1:0]   hop;
		logic [COST_W-1:0] cost;
		logic              done;
	} res_t;

endpackage

@@ src/stre_queue.sv @@
// ---------------------------------------------------------------------------
// stre_queue
// Small first-in first-out buffer with full and empty flags.
// ---------------------------------------------------------------------------
module stre_queue #(
	parameter int unsigned W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int D   = stre_pkg::QUEUE_DEPTH;
	localparam int PW  = (D > 1) ? $clog2(D) : 1;
	localparam int CTW = $clog2(D + 1);

	logic [W-1:0]   mem_q [D];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [CTW-1:0] cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CTW'(D));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(D - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(D - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CTW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

@@ src/stre_front.sv @@
// ---------------------------------------------------------------------------
// stre_front
// Accepts input transactions, checks indexes, saturates the operand and
// turns each item into a command for the execution unit.
// ---------------------------------------------------------------------------
module stre_front #(
	parameter int MAX_NODES
) (
	input  logic                        push,
	output logic                        full,
	input  logic [stre_pkg::FUNC_W-1:0] func,
	input  logic [stre_pkg::IDX_W-1:0]  node_index,
	input  logic [stre_pkg::IDX_W-1:0]  peer_index,
	input  logic [stre_pkg::VAL_W-1:0]  value,
	input  logic                        q_full,
	input  logic                        clearing,
	output logic                        cmd_push,
	output stre_pkg::cmd_t              cmd
);

	logic                       node_ok;
	logic                       peer_ok;
	logic [stre_pkg::VAL_W-1:0] id_sat;
	logic [stre_pkg::VAL_W-1:0] cost_sat;

	assign node_ok  = (32'(node_index) < MAX_NODES);
	assign peer_ok  = (32'(peer_index) < MAX_NODES);
	assign id_sat   = (32'(value) > stre_pkg::ID_MAX) ?
		stre_pkg::VAL_W'(stre_pkg::ID_MAX) : value;
	assign cost_sat = (32'(value) > stre_pkg::COST_MAX) ?
		stre_pkg::VAL_W'(stre_pkg::COST_MAX) : value;

	assign full     = q_full || clearing;
	assign cmd_push = push && !full;

	always_comb begin
		cmd.node  = node_index;
		cmd.peer  = peer_index;
		cmd.value = cost_sat;
		cmd.op    = stre_pkg::OP_SHOW;
		if (!node_ok) begin
			cmd.op = stre_pkg::OP_BLANK;
		end else begin
			unique case (func)
				stre_pkg::FUNC_LOAD_ID: begin
					cmd.op    = stre_pkg::OP_LOAD_ID;
					cmd.value = id_sat;
				end
				stre_pkg::FUNC_LOAD_LINK: begin
					cmd.op = peer_ok ? stre_pkg::OP_LOAD_LINK : stre_pkg::OP_SHOW;
				end
				stre_pkg::FUNC_UPDATE: begin
					cmd.op = stre_pkg::OP_UPDATE;
				end
				default: begin
					cmd.op = stre_pkg::OP_SHOW;
				end
			endcase
		end
	end

endmodule

@@ src/stre_back.sv @@
// ---------------------------------------------------------------------------
// stre_back
// Execution unit: node table and link matrix memories, a sequencer that runs
// id loads, link loads and neighbour scans, and result assembly.
// ---------------------------------------------------------------------------
module stre_back #(
	parameter int MAX_NODES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [stre_pkg::NCNT_W-1:0]  node_count,
	input  stre_pkg::cmd_t               cmd,
	input  logic                         cmd_empty,
	output logic                         cmd_pop,
	output stre_pkg::res_t               res,
	output logic                         res_push,
	input  logic                         res_full,
	output logic                         clearing
);

	localparam int NW     = $clog2(MAX_NODES);
	localparam int CW     = $clog2(MAX_NODES + 1);
	localparam int LW     = 2 * NW;
	localparam int LDEPTH = 1 << LW;
	localparam int CNTW   = stre_pkg::CNT_W;
	localparam int COSTW  = stre_pkg::COST_W;

	stre_pkg::st_t  st_q;
	stre_pkg::st_t  st_d;
	stre_pkg::cmd_t cur_q;
	stre_pkg::node_t work_q;

	logic [MAX_NODES-1:0] def_q;
	logic [CNTW-1:0]      cnt_q [MAX_NODES];
	logic [LW-1:0]        clr_q;
	logic                 wr_me_q;
	logic [NW-1:0]        scan_q;
	logic [NW-1:0]        scan_s1;
	logic                 scan_v_s1;

	stre_pkg::node_t            node_mem [MAX_NODES];
	stre_pkg::node_t            node_rd_s1;
	logic [stre_pkg::VAL_W-1:0] link_mem [LDEPTH];
	logic [stre_pkg::VAL_W-1:0] link_rd_s1;

	logic [CW-1:0]              n_eff;
	logic [NW-1:0]              last_idx;
	logic [NW-1:0]              me;
	logic [NW-1:0]              peer;
	logic [NW-1:0]              node_ra;
	logic [LW-1:0]              link_ra;
	logic                       link_we;
	logic [LW-1:0]              link_wa;
	logic [stre_pkg::VAL_W-1:0] link_wd;
	stre_pkg::node_t            me_ent;
	stre_pkg::node_t            new_ent;
	logic [COSTW:0]             sum;
	logic [COSTW-1:0]           total;
	logic                       nb_ok;
	logic                       adopt;
	logic                       better;
	logic                       done;

	assign me       = NW'(cur_q.node);
	assign peer     = NW'(cur_q.peer);
	assign clearing = (st_q == stre_pkg::ST_CLEAR);

	always_comb begin
		if (node_count == '0) begin
			n_eff = CW'(1);
		end else if (32'(node_count) > MAX_NODES) begin
			n_eff = CW'(MAX_NODES);
		end else begin
			n_eff = CW'(node_count);
		end
	end

	assign last_idx = NW'(n_eff - CW'(1));
	assign node_ra  = (st_q == stre_pkg::ST_IDLE) ? NW'(cmd.node) : scan_q;
	assign link_ra  = {me, scan_q};

	assign me_ent  = def_q[me] ? node_rd_s1 : '0;
	assign new_ent = '{bridge: cur_q.value, root: cur_q.value, hop: cur_q.value,
		cost: '0};

	assign sum    = {1'b0, node_rd_s1.cost} + (COSTW + 1)'(link_rd_s1);
	assign total  = (sum > {1'b0, stre_pkg::COST_SAT}) ? stre_pkg::COST_SAT :
		sum[COSTW-1:0];
	assign nb_ok  = scan_v_s1 && (link_rd_s1 != '0) && def_q[scan_s1];
	assign adopt  = nb_ok && (work_q.root > node_rd_s1.root);
	assign better = nb_ok && (work_q.root == node_rd_s1.root) && (work_q.cost > total);

	always_comb begin
		done = 1'b1;
		for (int k = 0; k < MAX_NODES; k++) begin
			if ((k < int'(n_eff)) && (int'(cnt_q[k]) < int'(n_eff))) begin
				done = 1'b0;
			end
		end
	end

	assign res = '{root: work_q.root, hop: work_q.hop, cost: work_q.cost, done: done};

	always_comb begin
		link_we = 1'b0;
		link_wa = clr_q;
		link_wd = '0;
		if (st_q == stre_pkg::ST_CLEAR) begin
			link_we = 1'b1;
		end else if ((st_q == stre_pkg::ST_READ_ME) &&
				(cur_q.op == stre_pkg::OP_LOAD_LINK)) begin
			link_we = 1'b1;
			link_wa = {me, peer};
			link_wd = cur_q.value;
		end else if (st_q == stre_pkg::ST_LINK2) begin
			link_we = 1'b1;
			link_wa = {peer, me};
			link_wd = cur_q.value;
		end
	end

	always_comb begin
		st_d     = st_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		unique case (st_q)
			stre_pkg::ST_CLEAR: begin
				if (clr_q == LW'(LDEPTH - 1)) begin
					st_d = stre_pkg::ST_IDLE;
				end
			end
			stre_pkg::ST_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					st_d    = stre_pkg::ST_READ_ME;
				end
			end
			stre_pkg::ST_READ_ME: begin
				unique case (cur_q.op)
					stre_pkg::OP_LOAD_LINK: st_d = stre_pkg::ST_LINK2;
					stre_pkg::OP_UPDATE:    st_d = stre_pkg::ST_SCAN;
					default:                st_d = stre_pkg::ST_RESULT;
				endcase
			end
			stre_pkg::ST_LINK2: begin
				st_d = stre_pkg::ST_RESULT;
			end
			stre_pkg::ST_SCAN: begin
				if (scan_q == last_idx) begin
					st_d = stre_pkg::ST_DRAIN;
				end
			end
			stre_pkg::ST_DRAIN: begin
				st_d = stre_pkg::ST_RESULT;
			end
			stre_pkg::ST_RESULT: begin
				res_push = 1'b1;
				st_d     = stre_pkg::ST_IDLE;
			end
			default: begin
				st_d = stre_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= stre_pkg::ST_CLEAR;
			clr_q     <= '0;
			def_q     <= '0;
			wr_me_q   <= 1'b0;
			scan_v_s1 <= 1'b0;
			for (int k = 0; k < MAX_NODES; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			st_q      <= st_d;
			scan_v_s1 <= (st_q == stre_pkg::ST_SCAN);
			if (st_q == stre_pkg::ST_CLEAR) begin
				clr_q <= clr_q + LW'(1);
			end
			if (st_q == stre_pkg::ST_READ_ME) begin
				wr_me_q <= ((cur_q.op == stre_pkg::OP_LOAD_ID) && !def_q[me]) ||
					(cur_q.op == stre_pkg::OP_UPDATE);
				if ((cur_q.op == stre_pkg::OP_LOAD_ID) && !def_q[me]) begin
					def_q[me] <= 1'b1;
					cnt_q[me] <= '0;
				end else if (cur_q.op == stre_pkg::OP_UPDATE) begin
					if (cnt_q[me] < stre_pkg::COUNT_SAT) begin
						cnt_q[me] <= cnt_q[me] + CNTW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		scan_s1 <= scan_q;
		if (st_q == stre_pkg::ST_READ_ME) begin
			scan_q <= '0;
			if (cur_q.op == stre_pkg::OP_BLANK) begin
				work_q <= '0;
			end else if ((cur_q.op == stre_pkg::OP_LOAD_ID) && !def_q[me]) begin
				work_q <= new_ent;
			end else begin
				work_q <= me_ent;
			end
		end else begin
			if (st_q == stre_pkg::ST_SCAN) begin
				scan_q <= scan_q + NW'(1);
			end
			if (adopt) begin
				work_q.root <= node_rd_s1.root;
				work_q.hop  <= node_rd_s1.bridge;
				work_q.cost <= total;
			end else if (better) begin
				work_q.hop  <= node_rd_s1.bridge;
				work_q.cost <= total;
			end
		end
	end

	always_ff @(posedge clk) begin
		node_rd_s1 <= node_mem[node_ra];
		if ((st_q == stre_pkg::ST_RESULT) && wr_me_q) begin
			node_mem[me] <= work_q;
		end
	end

	always_ff @(posedge clk) begin
		link_rd_s1 <= link_mem[link_ra];
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
	end

endmodule

@@ src/spanning_tree_root_election.sv @@
// ---------------------------------------------------------------------------
// spanning_tree_root_election
// Root election over a node table and a symmetric link cost matrix: loads
// node ids and link costs and runs per-node neighbour updates.
//
//   channel  handshake            payload
//   input    push / full          func, node_index, peer_index, value
//   result   empty / pop          root_id, next_hop_id, cost_to_root, tree_done
//   config   cfg_valid/cfg_ready  cfg_data (node_count)
//
// Update: read the node entry, scan the n nodes in use one entry per cycle,
// drain, return the result. Link load: write both matrix halves, then the
// result; other items return after the read. After reset all link entries,
// 2^(2*ceil(log2(MAX_NODES))) (256 by default), are cleared, full held high.
// A two-entry command queue decouples intake from execution; execution
// waits while the two-entry result queue is full.
// ---------------------------------------------------------------------------
module spanning_tree_root_election #(
	parameter int MAX_NODES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [stre_pkg::FUNC_W-1:0]  func,
	input  logic [stre_pkg::IDX_W-1:0]   node_index,
	input  logic [stre_pkg::IDX_W-1:0]   peer_index,
	input  logic [stre_pkg::VAL_W-1:0]   value,
	output logic                         empty,
	input  logic                         pop,
	output logic [stre_pkg::ID_W-1:0]    root_id,
	output logic [stre_pkg::ID_W-1:0]    next_hop_id,
	output logic [stre_pkg::COST_W-1:0]  cost_to_root,
	output logic                         tree_done,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [stre_pkg::NCNT_W-1:0]  cfg_data
);

	logic [stre_pkg::NCNT_W-1:0] node_count_q;
	stre_pkg::cmd_t              cmd_in;
	stre_pkg::cmd_t              cmd_head;
	stre_pkg::res_t              res_in;
	stre_pkg::res_t              res_head;
	logic                        cmd_push;
	logic                        cmd_full;
	logic                        cmd_empty;
	logic                        cmd_pop;
	logic                        res_push;
	logic                        res_full;
	logic                        clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= stre_pkg::NCNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	stre_front #(
		.MAX_NODES (MAX_NODES)
	) u_front (
		.push       (push),
		.full       (full),
		.func       (func),
		.node_index (node_index),
		.peer_index (peer_index),
		.value      (value),
		.q_full     (cmd_full),
		.clearing   (clearing),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	stre_queue #(
		.W ($bits(stre_pkg::cmd_t))
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	stre_back #(
		.MAX_NODES (MAX_NODES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_count (node_count_q),
		.cmd        (cmd_head),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.res        (res_in),
		.res_push   (res_push),
		.res_full   (res_full),
		.clearing   (clearing)
	);

	stre_queue #(
		.W ($bits(stre_pkg::res_t))
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign root_id      = res_head.root;
	assign next_hop_id  = res_head.hop;
	assign cost_to_root = res_head.cost;
	assign tree_done    = res_head.done;

endmodule

@@ src/stre_checker.sv @@
// ---------------------------------------------------------------------------
// stre_checker
// Port-level checks on the root election block: transaction balance between
// input and result channels and stability of a waiting result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stre_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         push,
	input logic                         full,
	input logic                         pop,
	input logic                         empty,
	input logic [stre_pkg::ID_W-1:0]    root_id,
	input logic [stre_pkg::ID_W-1:0]    next_hop_id,
	input logic [stre_pkg::COST_W-1:0]  cost_to_root,
	input logic                         tree_done
);

	localparam logic [3:0] OUT_MAX = 4'd5;

	logic [3:0] outst_q;
	logic       in_acc;
	logic       out_acc;
	logic [2*stre_pkg::ID_W+stre_pkg::COST_W:0] res_bus;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;
	assign res_bus = {root_id, next_hop_id, cost_to_root, tree_done};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else if (in_acc && !out_acc) begin
			outst_q <= outst_q + 4'd1;
		end else if (out_acc && !in_acc) begin
			outst_q <= outst_q - 4'd1;
		end
	end

	`CHK_IMPLY(a_no_spurious_result, !empty, outst_q != 4'd0, "result without accepted item")
	`CHK_IMPLY(a_bounded_inflight, 1'b1, outst_q <= OUT_MAX, "too many items in flight")
	`CHK_NEXT(a_result_holds, !empty && !pop, !empty && $stable(res_bus), "waiting result changed")

endmodule

bind spanning_tree_root_election stre_checker u_stre_checker (.*);

@@ sim/root_election_checker.sv @@
// ---------------------------------------------------------------------------
// root_election_checker
// Watches the item, result and node-count channels of the root election
// block, keeps its own copy of the node table and link costs, works out the
// expected result of every accepted item and compares it, field by field,
// with the result that the block returns.
// ---------------------------------------------------------------------------
module root_election_checker
	import stre_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [FUNC_W-1:0] func,
	input  logic [IDX_W-1:0]  node_index,
	input  logic [IDX_W-1:0]  peer_index,
	input  logic [VAL_W-1:0]  value,
	input  logic              empty,
	input  logic              pop,
	input  logic [ID_W-1:0]   root_id,
	input  logic [ID_W-1:0]   next_hop_id,
	input  logic [COST_W-1:0] cost_to_root,
	input  logic              tree_done,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [NCNT_W-1:0] cfg_data,
	output int                mismatches,
	output int                outstanding,
	output int                compared,
	output int                done_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 16;

	logic [ID_W-1:0]   bridge [NODES];
	logic [ID_W-1:0]   root [NODES];
	logic [ID_W-1:0]   hop [NODES];
	logic [COST_W-1:0] cost [NODES];
	logic [CNT_W-1:0]  upd [NODES];
	logic              known [NODES];
	logic [VAL_W-1:0]  weight [NODES][NODES];
	logic [NCNT_W-1:0] ncount;
	res_t              tree_q[$];
	res_t              head;

	function automatic res_t elect_step(input logic [FUNC_W-1:0] f,
		input logic [IDX_W-1:0] me, input logic [IDX_W-1:0] peer,
		input logic [VAL_W-1:0] val);
		int                n;
		logic [VAL_W-1:0]  w;
		logic [COST_W-1:0] total;
		res_t              r;
		n = (ncount == 0) ? 1 : ((ncount > NODES) ? NODES : int'(ncount));
		case (f)
			FUNC_LOAD_ID: begin
				if (!known[me]) begin
					bridge[me] = val;
					root[me]   = val;
					hop[me]    = val;
					cost[me]   = '0;
					upd[me]    = '0;
					known[me]  = 1'b1;
				end
			end
			FUNC_LOAD_LINK: begin
				weight[me][peer] = val;
				weight[peer][me] = val;
			end
			FUNC_UPDATE: begin
				if (upd[me] < COUNT_SAT)
					upd[me] = upd[me] + 1'b1;
				for (int i = 0; i < n; i++) begin
					w = weight[me][i];
					if (w == 0 || !known[i])
						continue;
					total = (({1'b0, cost[i]} + w) > COST_SAT) ? COST_SAT : cost[i] + w;
					if (root[me] > root[i]) begin
						root[me] = root[i];
						hop[me]  = bridge[i];
						cost[me] = total;
					end else if (root[me] == root[i] && cost[me] > total) begin
						hop[me]  = bridge[i];
						cost[me] = total;
					end
				end
			end
			default: ;
		endcase
		r.root = root[me];
		r.hop  = hop[me];
		r.cost = cost[me];
		r.done = 1'b1;
		for (int i = 0; i < n; i++)
			if (upd[i] < n)
				r.done = 1'b0;
		return r;
	endfunction

	task automatic check_field(input string tag, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0d, actual %0d", $time, tag, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (bridge[i]) begin
				bridge[i] = '0;
				root[i]   = '0;
				hop[i]    = '0;
				cost[i]   = '0;
				upd[i]    = '0;
				known[i]  = 1'b0;
				foreach (weight[i][j])
					weight[i][j] = '0;
			end
			ncount = NCNT_RESET;
			tree_q.delete();
			mismatches  = 0;
			compared    = 0;
			done_count  = 0;
			outstanding = 0;
		end else begin
			if (pop && !empty) begin
				if (tree_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected (root %0d, hop %0d, cost %0d)",
						$time, root_id, next_hop_id, cost_to_root);
				end else begin
					head = tree_q.pop_front();
					check_field("root_id", 16'(head.root), 16'(root_id));
					check_field("next_hop_id", 16'(head.hop), 16'(next_hop_id));
					check_field("cost_to_root", 16'(head.cost), 16'(cost_to_root));
					check_field("tree_done", 16'(head.done), 16'(tree_done));
					compared++;
					if (head.done)
						done_count++;
				end
			end
			if (push && !full)
				tree_q.push_back(elect_step(func, node_index, peer_index, value));
			if (cfg_valid && cfg_ready)
				ncount = cfg_data;
			outstanding = tree_q.size();
		end
	end

endmodule

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the root election block: a directed opening of
// id loads, link loads and updates, then random phases under several node
// counts, with random idling on both queues and a quiet final phase.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stre_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE      = 24;
	localparam int PHASE_ITEMS = 70;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic [FUNC_W-1:0] func = '0;
	logic [IDX_W-1:0]  node_index = '0;
	logic [IDX_W-1:0]  peer_index = '0;
	logic [VAL_W-1:0]  value = '0;
	logic              pop = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [NCNT_W-1:0] cfg_data = '0;
	logic              full;
	logic              empty;
	logic [ID_W-1:0]   root_id;
	logic [ID_W-1:0]   next_hop_id;
	logic [COST_W-1:0] cost_to_root;
	logic              tree_done;
	logic              cfg_ready;

	int mismatches;
	int outstanding;
	int compared;
	int done_count;
	int items_sent = 0;
	int settings_used = 0;
	int idle_run = 0;
	bit quiet = 1'b0;

	spanning_tree_root_election dut (.*);
	root_election_checker checker_i (.*);

	initial forever #6 clk = ~clk;

	initial begin : pop_side
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 6) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			idle_run <= 0;
		end else if (idle_run >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	task automatic put_item(input logic [FUNC_W-1:0] f, input int me, input int peer,
		input int v);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push       <= 1'b1;
		func       <= f;
		node_index <= IDX_W'(me);
		peer_index <= IDX_W'(peer);
		value      <= VAL_W'(v);
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	task automatic settle();
		push <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_node_count(input int nc);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= NCNT_W'(nc);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic random_item(input int n);
		int r;
		int me;
		int peer;
		int c;
		r    = $urandom_range(0, 99);
		me   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
		peer = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
		c    = $urandom_range(0, 9);
		c    = (c == 0) ? 0 : ((c == 1) ? COST_MAX : $urandom_range(1, 255));
		if (r < 50)
			put_item(FUNC_UPDATE, me, $urandom_range(0, 15), $urandom_range(0, 255));
		else if (r < 75)
			put_item(FUNC_LOAD_LINK, me, peer, c);
		else if (r < 92)
			put_item(FUNC_LOAD_ID, me, $urandom_range(0, 15), $urandom_range(0, 255));
		else if (r < 96)
			put_item(FUNC_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 255));
		else
			put_item(FUNC_UPDATE, $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 255));
	endtask

	initial begin : stimulus
		int counts [9];
		int n;
		counts = '{2, 0, 4, 1, 17, 8, 31, 5, 16};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		put_item(FUNC_UPDATE, 3, 0, 0);
		put_item(FUNC_NONE, 15, 15, 255);
		put_item(FUNC_LOAD_ID, 0, 0, 255);
		put_item(FUNC_LOAD_ID, 14, 15, 0);
		put_item(FUNC_LOAD_ID, 1, 0, 40);
		put_item(FUNC_LOAD_ID, 2, 0, 90);
		put_item(FUNC_LOAD_ID, 15, 0, 200);
		put_item(FUNC_LOAD_ID, 1, 0, 7);
		put_item(FUNC_LOAD_LINK, 0, 1, 255);
		put_item(FUNC_LOAD_LINK, 1, 2, 1);
		put_item(FUNC_LOAD_LINK, 2, 15, 0);
		put_item(FUNC_LOAD_LINK, 15, 2, 100);
		put_item(FUNC_LOAD_LINK, 0, 0, 5);
		put_item(FUNC_LOAD_LINK, 3, 4, 9);
		put_item(FUNC_LOAD_LINK, 14, 15, 0);
		put_item(FUNC_UPDATE, 0, 0, 0);
		put_item(FUNC_UPDATE, 2, 0, 0);
		put_item(FUNC_UPDATE, 15, 0, 0);
		put_item(FUNC_UPDATE, 0, 0, 0);
		put_item(FUNC_UPDATE, 3, 0, 0);
		put_item(FUNC_LOAD_LINK, 0, 2, 10);
		put_item(FUNC_UPDATE, 0, 15, 255);
		put_item(FUNC_UPDATE, 1, 0, 0);
		put_item(FUNC_NONE, 0, 0, 0);

		foreach (counts[p]) begin
			if (p == 8)
				quiet = 1'b1;
			set_node_count(counts[p]);
			n = (counts[p] == 0) ? 1 : ((counts[p] > 16) ? 16 : counts[p]);
			if (counts[p] == 17) begin
				for (int i = 0; i < 16; i++)
					put_item(FUNC_LOAD_ID, i, $urandom_range(0, 15), $urandom_range(0, 255));
				for (int i = 0; i < 15; i++)
					put_item(FUNC_LOAD_LINK, i, i + 1, COST_MAX);
				for (int s = 0; s < 3; s++)
					for (int i = 0; i < 16; i++)
						put_item(FUNC_UPDATE, (s % 2) ? 15 - i : i, $urandom_range(0, 15),
							$urandom_range(0, 255));
			end
			repeat (PHASE_ITEMS) random_item(n);
		end

		settle();
		$display("Run covered %0d items over %0d node-count settings.",
			items_sent, settings_used);
		$display("%0d results compared, %0d with the tree finished.",
			compared, done_count);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
